// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/rmoi_pkg.sv -----
package rmoi_pkg;

  localparam int MARGIN_WIDTH = 7;
  localparam int INDEX_WIDTH  = 8;
  localparam int STATUS_WIDTH = 2;
  localparam int LIMIT_WIDTH  = 15;

  typedef enum logic [1:0] {
    COORD_X,
    COORD_Y,
    COORD_Z
  } coord_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    coord_sel_t sel;
    acc_op_t    acc_op;
  } dist_ctrl_t;

endpackage

// ----- hw/rtl/rmoi_store.sv -----
module rmoi_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/rmoi_dist.sv -----
module rmoi_dist #(
  parameter int CW = 16
) (
  input  logic                                clk,
  input  rmoi_pkg::dist_ctrl_t                ctrl,
  input  logic [3*CW-1:0]                     entry,
  input  logic signed [CW-1:0]                qx,
  input  logic signed [CW-1:0]                qy,
  input  logic signed [CW-1:0]                qz,
  input  logic [rmoi_pkg::LIMIT_WIDTH-1:0]    limit,
  output logic                                hit
);

  localparam int SQW  = 2 * CW + 1;
  localparam int SUMW = 2 * CW + 2;

  logic [CW-1:0]          ent_sel;
  logic [CW-1:0]          q_sel;
  logic signed [CW:0]     ent_ext;
  logic signed [CW:0]     q_ext;
  logic signed [CW:0]     diff_r;
  logic signed [2*CW+1:0] prod;
  logic [SQW-1:0]         sq_r;
  logic [SUMW-1:0]        acc_r;
  logic [SUMW-1:0]        total;

  always_comb begin
    case (ctrl.sel)
      rmoi_pkg::COORD_X: begin
        ent_sel = entry[CW-1:0];
        q_sel   = qx;
      end
      rmoi_pkg::COORD_Y: begin
        ent_sel = entry[2*CW-1:CW];
        q_sel   = qy;
      end
      rmoi_pkg::COORD_Z: begin
        ent_sel = entry[3*CW-1:2*CW];
        q_sel   = qz;
      end
      default: begin
        ent_sel = entry[CW-1:0];
        q_sel   = qx;
      end
    endcase
  end

  assign ent_ext = {ent_sel[CW-1], ent_sel};
  assign q_ext   = {q_sel[CW-1], q_sel};
  assign prod    = diff_r * diff_r;

  always_ff @(posedge clk) begin
    diff_r <= ent_ext - q_ext;
    sq_r   <= prod[SQW-1:0];
    case (ctrl.acc_op)
      rmoi_pkg::ACC_LOAD: acc_r <= SUMW'(sq_r);
      rmoi_pkg::ACC_ADD:  acc_r <= acc_r + SUMW'(sq_r);
      default:            acc_r <= acc_r;
    endcase
  end

  assign total = acc_r + SUMW'(sq_r);
  assign hit   = total < SUMW'(limit);

endmodule

// ----- hw/rtl/radius_match_or_insert_table.sv -----
// Channel  Ports                                   Direction  Beat
// in       in_valid, in_stall, in_point_x/y/z,     input      one query point
//          in_margin
// out      out_valid, out_stall, out_entry_index,  output     one result
//          out_status
//
// A query scans the stored entries one after another, set by the single
// squarer that handles x, y and z of an entry in turn.
// Reset clears the entry count; the point memory needs no clearing pass.
// in_stall goes high after a beat is accepted and stays high until its result is loaded.
// A stalled result holds in the output register while the next query is taken.
`include "assert_macros.svh"

module radius_match_or_insert_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  logic [rmoi_pkg::MARGIN_WIDTH-1:0]    in_margin,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rmoi_pkg::INDEX_WIDTH-1:0]     out_entry_index,
  output logic [rmoi_pkg::STATUS_WIDTH-1:0]    out_status
);

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW   = $clog2(TABLE_DEPTH + 1);
  localparam int XW     = (AW > rmoi_pkg::INDEX_WIDTH) ? AW : rmoi_pkg::INDEX_WIDTH;
  localparam int RADW   = 8;
  localparam int RadiusBase = 128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PX,
    S_PY,
    S_PZ,
    S_SQZ,
    S_CMP,
    S_INS,
    S_DONE
  } state_t;

  typedef enum logic [rmoi_pkg::STATUS_WIDTH-1:0] {
    ST_MATCH  = 2'd0,
    ST_INSERT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  state_t                            state_r, state_nxt;
  logic [AW-1:0]                     idx_r, idx_nxt;
  logic [CNTW-1:0]                   count_r, count_nxt;
  logic signed [CW-1:0]              qx_r, qx_nxt;
  logic signed [CW-1:0]              qy_r, qy_nxt;
  logic signed [CW-1:0]              qz_r, qz_nxt;
  logic [rmoi_pkg::LIMIT_WIDTH-1:0]  limit_r, limit_nxt;
  logic [AW-1:0]                     res_idx_r, res_idx_nxt;
  status_t                           res_status_r, res_status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [rmoi_pkg::INDEX_WIDTH-1:0]  out_idx_r, out_idx_nxt;
  status_t                           out_status_r, out_status_nxt;

  logic [RADW-1:0]                   radius;
  logic [2*RADW-1:0]                 rad_sq;
  logic [CNTW-1:0]                   idx_inc;
  logic [XW-1:0]                     res_idx_ext;
  logic                              table_full;
  logic                              hit;
  logic                              wr_en;
  logic [3*CW-1:0]                   rd_data;
  rmoi_pkg::dist_ctrl_t              ctrl;

  assign radius      = RADW'(RadiusBase) - RADW'(in_margin);
  assign rad_sq      = radius * radius;
  assign idx_inc     = CNTW'(idx_r) + CNTW'(1);
  assign res_idx_ext = XW'(res_idx_r);
  assign table_full  = count_r == CNTW'(TABLE_DEPTH);

  rmoi_store #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (3 * CW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({qz_r, qy_r, qx_r}),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  rmoi_dist #(
    .CW (CW)
  ) u_dist (
    .clk   (clk),
    .ctrl  (ctrl),
    .entry (rd_data),
    .qx    (qx_r),
    .qy    (qy_r),
    .qz    (qz_r),
    .limit (limit_r),
    .hit   (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    qz_nxt         = qz_r;
    limit_nxt      = limit_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    ctrl.sel       = rmoi_pkg::COORD_X;
    ctrl.acc_op    = rmoi_pkg::ACC_HOLD;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          qx_nxt    = in_point_x;
          qy_nxt    = in_point_y;
          qz_nxt    = in_point_z;
          limit_nxt = rad_sq[rmoi_pkg::LIMIT_WIDTH-1:0];
          idx_nxt   = '0;
          state_nxt = (count_r == '0) ? S_INS : S_PX;
        end
      end
      S_PX: begin
        ctrl.sel  = rmoi_pkg::COORD_X;
        state_nxt = S_PY;
      end
      S_PY: begin
        ctrl.sel  = rmoi_pkg::COORD_Y;
        state_nxt = S_PZ;
      end
      S_PZ: begin
        ctrl.sel    = rmoi_pkg::COORD_Z;
        ctrl.acc_op = rmoi_pkg::ACC_LOAD;
        state_nxt   = S_SQZ;
      end
      S_SQZ: begin
        ctrl.acc_op = rmoi_pkg::ACC_ADD;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          res_idx_nxt    = idx_r;
          res_status_nxt = ST_MATCH;
          state_nxt      = S_DONE;
        end else if (idx_inc == count_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt   = idx_inc[AW-1:0];
          state_nxt = S_PX;
        end
      end
      S_INS: begin
        if (table_full) begin
          res_idx_nxt    = '0;
          res_status_nxt = ST_FULL;
        end else begin
          wr_en          = 1'b1;
          res_idx_nxt    = count_r[AW-1:0];
          res_status_nxt = ST_INSERT;
          count_nxt      = count_r + CNTW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_ext[rmoi_pkg::INDEX_WIDTH-1:0];
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    qz_r         <= qz_nxt;
    limit_r      <= limit_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_entry_index = out_idx_r;
  assign out_status      = out_status_r;

  `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_r <= CNTW'(TABLE_DEPTH), "entry count overflow")
  `ASSERT_HOLDS(a_busy_after_beat, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "not busy after beat")
  `ASSERT_HOLDS(a_count_step, clk, rst_n, ($past(rst_n) && count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNTW'(1)), "entry count jumped")
  `ASSERT_NEVER(a_no_write_full, clk, rst_n, wr_en && table_full, "write into full table")

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 256;
  localparam int COORD_WIDTH  = 16;
  localparam int MARGIN_W     = rmoi_pkg::MARGIN_WIDTH;
  localparam int IDX_W        = rmoi_pkg::INDEX_WIDTH;
  localparam int STAT_W       = rmoi_pkg::STATUS_WIDTH;
  localparam int RADIUS_BASE  = 128;
  localparam int COORD_MAX    = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (COORD_WIDTH - 1));
  localparam int NUM_RANDOM   = 1530;
  localparam int LONG_HOLD    = 4000;
  localparam int DRAIN_CYCLES = 1400;
  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [STAT_W-1:0] {
    ST_MATCHED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } lookup_status_e;

  typedef struct {
    logic [IDX_W-1:0] entry_index;
    lookup_status_e   status;
  } lookup_result_t;

  typedef enum {RX_FREE, RX_CHOPPY, RX_HEAVY} rx_mode_e;

  class lookup_scoreboard;
    int             point_x [TABLE_DEPTH];
    int             point_y [TABLE_DEPTH];
    int             point_z [TABLE_DEPTH];
    int unsigned    entry_count;
    lookup_result_t pending_lookups[$];
    int unsigned    queries_noted;
    int unsigned    n_matched;
    int unsigned    n_inserted;
    int unsigned    n_full;
    int unsigned    mismatches;

    function new();
      entry_count   = 0;
      queries_noted = 0;
      n_matched     = 0;
      n_inserted    = 0;
      n_full        = 0;
      mismatches    = 0;
    endfunction

    function void predict_lookup(int qx, int qy, int qz, int unsigned margin);
      lookup_result_t res;
      longint         dx;
      longint         dy;
      longint         dz;
      longint         dist2;
      longint         radius2;
      bit             found;
      radius2 = longint'(RADIUS_BASE - margin) * longint'(RADIUS_BASE - margin);
      found   = 1'b0;
      for (int i = 0; i < int'(entry_count) && !found; i++) begin
        dx    = longint'(point_x[i]) - qx;
        dy    = longint'(point_y[i]) - qy;
        dz    = longint'(point_z[i]) - qz;
        dist2 = dx * dx + dy * dy + dz * dz;
        if (dist2 < radius2) begin
          found           = 1'b1;
          res.entry_index = i[IDX_W-1:0];
          res.status      = ST_MATCHED;
        end
      end
      if (found) begin
        n_matched++;
      end else if (entry_count < TABLE_DEPTH) begin
        point_x[entry_count] = qx;
        point_y[entry_count] = qy;
        point_z[entry_count] = qz;
        res.entry_index      = entry_count[IDX_W-1:0];
        res.status           = ST_INSERTED;
        entry_count++;
        n_inserted++;
      end else begin
        res.entry_index = '0;
        res.status      = ST_FULL;
        n_full++;
      end
      pending_lookups.push_back(res);
      queries_noted++;
    endfunction

    function void check_lookup_result(logic [IDX_W-1:0] idx, logic [STAT_W-1:0] st);
      lookup_result_t exp;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result beat: index %0d status %0d", idx, st);
        return;
      end
      exp = pending_lookups.pop_front();
      if (idx !== exp.entry_index || st !== exp.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Mismatch: expected index %0d status %s, got index %0d status %0d",
                   exp.entry_index, exp.status.name(), idx, st);
      end
    endfunction

    function int unsigned pending();
      return pending_lookups.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] in_point_x = '0;
  logic signed [COORD_WIDTH-1:0] in_point_y = '0;
  logic signed [COORD_WIDTH-1:0] in_point_z = '0;
  logic [MARGIN_W-1:0]           in_margin = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [IDX_W-1:0]              out_entry_index;
  logic [STAT_W-1:0]             out_status;

  lookup_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_holds_done = 0;
  rx_mode_e    rx_mode = RX_FREE;

  radius_match_or_insert_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_margin      (in_margin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_entry_index(out_entry_index),
    .out_status     (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_lookup_result(out_entry_index, out_status);
      if (in_valid === 1'b1 && in_stall === 1'b0)
        sb.predict_lookup(int'(in_point_x), int'(in_point_y), int'(in_point_z),
                          in_margin);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_hold_left == 0 && rx_holds_done == 0 && sb.queries_noted >= 30) begin
        rx_hold_left  = LONG_HOLD;
        rx_holds_done = 1;
      end else if (rx_hold_left == 0 && rx_holds_done == 1 && sb.n_full >= 20) begin
        rx_hold_left  = LONG_HOLD;
        rx_holds_done = 2;
      end
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_e'($urandom_range(0, 2));
        rx_phase_left = $urandom_range(20, 200);
      end
      rx_phase_left--;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
          default:   out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Most queries land near a stored point so that matches, near misses and
  // the exact radius boundary all occur; the rest are fresh random points.
  function automatic void pick_query(output int qx, output int qy, output int qz,
                                     output int qm);
    int unsigned roll;
    int unsigned fresh_pct;
    int unsigned base;
    int unsigned axis;
    int          rad;
    int          off;
    roll      = $urandom_range(0, 99);
    fresh_pct = (sb.entry_count < TABLE_DEPTH) ? 30 : 20;
    qm        = $urandom_range(0, 2 ** MARGIN_W - 1);
    rad       = RADIUS_BASE - qm;
    if (sb.entry_count == 0 || roll < fresh_pct) begin
      qx = clamp_coord(int'($signed(COORD_WIDTH'($urandom))));
      qy = clamp_coord(int'($signed(COORD_WIDTH'($urandom))));
      qz = clamp_coord(int'($signed(COORD_WIDTH'($urandom))));
      return;
    end
    base = $urandom_range(0, sb.entry_count - 1);
    qx   = sb.point_x[base];
    qy   = sb.point_y[base];
    qz   = sb.point_z[base];
    if (roll < fresh_pct + 10) begin
      axis = $urandom_range(0, 2);
      off  = rad - int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) off = -off;
      if (axis == 0) qx = clamp_coord(qx + off);
      else if (axis == 1) qy = clamp_coord(qy + off);
      else qz = clamp_coord(qz + off);
    end else begin
      qx = clamp_coord(qx + int'($urandom_range(0, 2 * rad)) - rad);
      qy = clamp_coord(qy + int'($urandom_range(0, 2 * rad)) - rad);
      qz = clamp_coord(qz + int'($urandom_range(0, 2 * rad)) - rad);
    end
  endfunction

  task automatic send_query(input int qx, input int qy, input int qz, input int qm);
    in_point_x <= qx[COORD_WIDTH-1:0];
    in_point_y <= qy[COORD_WIDTH-1:0];
    in_point_z <= qz[COORD_WIDTH-1:0];
    in_margin  <= qm[MARGIN_W-1:0];
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin : stimulus
    int          qx;
    int          qy;
    int          qz;
    int          qm;
    int unsigned sent;
    int unsigned burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_sender(2);

    send_query(0, 0, 0, 0);
    send_query(128, 0, 0, 0);
    send_query(127, 0, 0, 0);
    send_query(100, 0, 0, 0);
    send_query(0, 0, 1, 127);
    send_query(0, 0, 0, 127);
    idle_sender(3);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX, 127);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN + 1, 127);
    send_query(COORD_MIN + 68, COORD_MIN, COORD_MIN, 63);
    send_query(-21846, 21845, -21846, 'h55);
    send_query(21845, -21846, 21845, 'h2A);
    send_query(21845, -21846, 21845, 'h2A);
    send_query(-1, -1, -1, 64);
    send_query(0, -1, 0, 64);
    send_query(COORD_MAX, COORD_MIN, 0, 1);
    send_query(COORD_MAX - 126, COORD_MIN, 0, 0);

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        pick_query(qx, qy, qz, qm);
        send_query(qx, qy, qz, qm);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 25));
    end
    idle_sender(0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d queries: %0d matched, %0d inserted, %0d refused by a full table.",
             sb.queries_noted, sb.n_matched, sb.n_inserted, sb.n_full);
    $display("The table ended with %0d of %0d entries; %0d mismatches were seen.",
             sb.entry_count, TABLE_DEPTH, sb.mismatches + sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
